// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions of the RTL blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/dwt_pkg.sv =====
// ----------------------------------------------------------------------------
// dwt_pkg
// Types and constants shared by the warble tone generator modules.
// ----------------------------------------------------------------------------
package dwt_pkg;

    // Register field widths.
    localparam int VOLUME_W = 7;
    localparam int INC_W    = 10;
    localparam int STEP_W   = 6;
    localparam int TICKS_W  = 16;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // The ROM holds the sine value already divided by the volume divisor.
    localparam int ROM_W          = 6;
    localparam int ROM_AMPLITUDE  = 2047;
    localparam int VOLUME_DIVISOR = 100;

    // Reset values.
    localparam logic [VOLUME_W-1:0] VOLUME_RESET    = 7'd50;
    localparam logic [INC_W-1:0]    INC_UPPER_RESET = 10'd341;
    localparam logic [STEP_W-1:0]   STEP_RESET      = 6'd4;
    localparam logic [TICKS_W-1:0]  TICKS_RESET     = 16'd3277;
    localparam logic [INC_W-1:0]    INC_RESET       = 10'd64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VOLUME           = 2'd0,
        CFG_INCREMENT_UPPER  = 2'd1,
        CFG_SWEEP_STEP       = 2'd2,
        CFG_TICKS_PER_TOGGLE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [VOLUME_W-1:0] volume;
        logic [INC_W-1:0]    increment_upper;
        logic [STEP_W-1:0]   sweep_step;
        logic [TICKS_W-1:0]  ticks_per_toggle;
    } dwt_cfg_t;

endpackage

// ===== hw/rtl/dwt_if.sv =====
// ----------------------------------------------------------------------------
// dwt_if
// Valid/ready channels of the warble tone generator: tick words in,
// sample words out.
// ----------------------------------------------------------------------------
interface dwt_tick_if;
    logic valid;
    logic ready;
    logic warble_enable;

    modport source (output valid, output warble_enable, input ready);
    modport sink   (input valid, input warble_enable, output ready);
endinterface

interface dwt_result_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic [9:0]             increment_now;

    modport source (output valid, output sample, output increment_now, input ready);
    modport sink   (input valid, input sample, input increment_now, output ready);
endinterface

// ===== hw/rtl/dwt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwt_ctrl
// Phase accumulator, toggle period counter and warble increment update.
// ----------------------------------------------------------------------------
module dwt_ctrl import dwt_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dwt_cfg_t                       cfg,
    input  logic                           advance,
    input  logic                           warble_enable,
    output logic [$clog2(TABLE_DEPTH)-1:0] phase,
    output logic [INC_W-1:0]               increment_next
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int PSUM_W = ((ADDR_W > INC_W) ? ADDR_W : INC_W) + 1;

    logic [ADDR_W-1:0]  phase_reg, phase_next;
    logic [INC_W-1:0]   increment_reg;
    logic [TICKS_W-1:0] tick_reg, tick_next;
    logic               raise_reg, raise_next;

    logic [PSUM_W-1:0]  phase_sum;
    logic [TICKS_W:0]   tick_plus;
    logic               wrap;
    logic [INC_W:0]     rise_sum;
    logic [INC_W-1:0]   ceiling;
    logic [INC_W-1:0]   rise_val;
    logic [INC_W-1:0]   drop_val;

    // The table depth is a power of two, so the wrap is a truncation.
    assign phase_sum = PSUM_W'(phase_reg) + PSUM_W'(increment_reg);
    assign tick_plus = {1'b0, tick_reg} + (TICKS_W+1)'(1);
    assign wrap      = tick_plus >= {1'b0, cfg.ticks_per_toggle};

    assign ceiling  = (cfg.increment_upper == '0) ? INC_W'(1) : cfg.increment_upper;
    assign rise_sum = {1'b0, increment_reg} + (INC_W+1)'(cfg.sweep_step);
    assign rise_val = (rise_sum > {1'b0, ceiling}) ? ceiling : rise_sum[INC_W-1:0];
    assign drop_val = (increment_reg <= INC_W'(cfg.sweep_step)) ? INC_W'(1)
                    : increment_reg - INC_W'(cfg.sweep_step);

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        raise_next     = raise_reg;
        increment_next = increment_reg;
        if (advance)
        begin
            phase_next = phase_sum[ADDR_W-1:0];
            if (wrap)
            begin
                tick_next = '0;
                if (warble_enable)
                begin
                    increment_next = raise_reg ? rise_val : drop_val;
                    raise_next     = !raise_reg;
                end
            end
            else
            begin
                tick_next = tick_plus[TICKS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            increment_reg <= INC_RESET;
            tick_reg      <= '0;
            raise_reg     <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            increment_reg <= increment_next;
            tick_reg      <= tick_next;
            raise_reg     <= raise_next;
        end
    end

    assign phase = phase_reg;

endmodule

// ===== hw/rtl/dwt_sine_rom.sv =====
// ----------------------------------------------------------------------------
// dwt_sine_rom
// Sine ROM with registered read. Each entry is trunc(sin(2*pi*i/depth)*2047)
// divided by the volume divisor toward zero, built at elaboration in exact
// fixed-point arithmetic.
// ----------------------------------------------------------------------------
module dwt_sine_rom import dwt_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] addr,
    output logic signed [ROM_W-1:0]        data
);

    localparam logic [63:0] DEPTH64 = 64'(TABLE_DEPTH);
    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q61 = 64'h2000000000000000;
    localparam logic [63:0] AMP64   = 64'(ROM_AMPLITUDE);
    localparam logic [63:0] DIV64   = 64'(VOLUME_DIVISOR);

    typedef logic signed [ROM_W-1:0] rom_array_t [TABLE_DEPTH];

    // Restoring division, used only while the table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mul_q61(input logic [63:0] x,
                                            input logic [63:0] y);
        logic [127:0] p;
        p = {64'b0, x} * {64'b0, y};
        return p[124:61];
    endfunction

    // Taylor series of sine or cosine for an angle in Q61 below pi/2.
    function automatic logic [63:0] series_q61(input logic [63:0] a,
                                               input logic want_cos);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic [63:0]        m;
        logic signed [63:0] sum;
        a2   = mul_q61(a, a);
        term = want_cos ? ONE_Q61 : a;
        sum  = signed'(term);
        for (int n = 1; n <= 16; n++)
        begin
            if (term != '0)
            begin
                m    = want_cos ? 64'(2 * n - 1) : 64'(2 * n);
                term = udiv64(mul_q61(term, a2), m * (m + 64'd1));
                if ((n & 1) != 0)
                    sum = sum - signed'(term);
                else
                    sum = sum + signed'(term);
            end
        end
        return (sum < 0) ? 64'd0 : unsigned'(sum);
    endfunction

    function automatic logic signed [ROM_W-1:0] sine_entry(input int i);
        logic [63:0] iv;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] ang;
        logic [63:0] mag;
        logic [63:0] v;
        logic [63:0] scaled;
        iv     = 64'(i);
        quad   = (64'd4 * iv) / DEPTH64;
        rem    = 64'd4 * iv - quad * DEPTH64;
        ang    = (PI_Q60 / DEPTH64) * rem + ((PI_Q60 % DEPTH64) * rem) / DEPTH64;
        mag    = series_q61(ang, quad[0]);
        v      = (AMP64 * (mag >> 30) + ((AMP64 * (mag & 64'h3FFFFFFF)) >> 30)) >> 31;
        if (v > AMP64)
            v = AMP64;
        scaled = v / DIV64;
        return (quad >= 64'd2) ? -ROM_W'(scaled) : ROM_W'(scaled);
    endfunction

    function automatic rom_array_t build_rom();
        rom_array_t r;
        for (int i = 0; i < TABLE_DEPTH; i++)
            r[i] = sine_entry(i);
        return r;
    endfunction

    localparam rom_array_t SINE_ROM = build_rom();

    logic signed [ROM_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
            data_reg <= SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

// ===== hw/rtl/dwt_scale.sv =====
// ----------------------------------------------------------------------------
// dwt_scale
// Volume multiply, midscale offset and saturation to the DAC code range.
// ----------------------------------------------------------------------------
module dwt_scale import dwt_pkg::*; #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic signed [ROM_W-1:0] sine_div,
    input  logic [VOLUME_W-1:0]     volume,
    output logic [SAMPLE_BITS-1:0]  sample
);

    localparam int PROD_W = ROM_W + VOLUME_W + 1;
    localparam int SUM_W  = ((SAMPLE_BITS > PROD_W) ? SAMPLE_BITS : PROD_W) + 2;
    localparam logic signed [SUM_W-1:0] MID = SUM_W'(1) <<< (SAMPLE_BITS - 1);
    localparam logic signed [SUM_W-1:0] TOP = (SUM_W'(1) <<< SAMPLE_BITS) - SUM_W'(1);

    logic signed [PROD_W-1:0] product;
    logic signed [SUM_W-1:0]  sum;

    assign product = PROD_W'(sine_div) * signed'({1'b0, volume});
    assign sum     = SUM_W'(product) + MID;

    always_comb
    begin
        priority if (sum < 0)
            sample = '0;
        else if (sum > TOP)
            sample = TOP[SAMPLE_BITS-1:0];
        else
            sample = sum[SAMPLE_BITS-1:0];
    end

endmodule

// ===== hw/rtl/dds_warble_tone_generator.sv =====
// ----------------------------------------------------------------------------
// dds_warble_tone_generator
// Sine tone generator for an alarm, with a warbling frequency.
//
// Every tick word yields one sample word: a sine value read at the current
// phase, scaled by the volume, offset to midscale and saturated to an unsigned
// DAC code, together with the phase increment in effect after the tick. The
// block takes one tick word per clock cycle unless the output stalls, and its
// sample passes through the registered sine ROM read and then the volume
// multiply into the output register. The output register lets the next tick
// word enter while a sample still waits. With warble enabled, the increment
// drops and rises by the sweep step each time the tick counter wraps, the
// first change being a drop. TABLE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dds_warble_tone_generator import dwt_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    dwt_tick_if.sink               tick,
    dwt_result_if.source           result
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    dwt_cfg_t cfg_reg;

    logic                    enable;
    logic                    accept;
    logic                    s1_valid_reg, s1_valid_next;
    logic [INC_W-1:0]        s1_inc_reg;
    logic                    res_valid_reg, res_valid_next;
    logic [SAMPLE_BITS-1:0]  res_sample_reg;
    logic [INC_W-1:0]        res_inc_reg;

    logic [ADDR_W-1:0]       phase;
    logic [INC_W-1:0]        increment_next;
    logic signed [ROM_W-1:0] sine_div;
    logic [SAMPLE_BITS-1:0]  scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volume           <= VOLUME_RESET;
            cfg_reg.increment_upper  <= INC_UPPER_RESET;
            cfg_reg.sweep_step       <= STEP_RESET;
            cfg_reg.ticks_per_toggle <= TICKS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_VOLUME:           cfg_reg.volume           <= cfg_data[VOLUME_W-1:0];
                CFG_INCREMENT_UPPER:  cfg_reg.increment_upper  <= cfg_data[INC_W-1:0];
                CFG_SWEEP_STEP:       cfg_reg.sweep_step       <= cfg_data[STEP_W-1:0];
                CFG_TICKS_PER_TOGGLE: cfg_reg.ticks_per_toggle <= cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or being read.
    assign enable     = !res_valid_reg || result.ready;
    assign tick.ready = !s1_valid_reg || enable;
    assign accept     = tick.valid && tick.ready;

    dwt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .advance        (accept),
        .warble_enable  (tick.warble_enable),
        .phase          (phase),
        .increment_next (increment_next)
    );

    dwt_sine_rom #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rom (
        .clk   (clk),
        .rd_en (accept),
        .addr  (phase),
        .data  (sine_div)
    );

    dwt_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .sine_div (sine_div),
        .volume   (cfg_reg.volume),
        .sample   (scaled)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        res_valid_next = res_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (enable)
            s1_valid_next = 1'b0;
        if (enable)
            res_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            s1_inc_reg    <= INC_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (accept)
                s1_inc_reg <= increment_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable && s1_valid_reg)
        begin
            res_sample_reg <= scaled;
            res_inc_reg    <= s1_inc_reg;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.sample        = res_sample_reg;
    assign result.increment_now = res_inc_reg;

    `ASSERT_SAME_CYCLE(a_stall_blocks_input, clk, rst_n, s1_valid_reg && !enable, !tick.ready)
    `ASSERT_NEXT_CYCLE(a_idle_stays_empty, clk, rst_n, !accept && !s1_valid_reg, !s1_valid_reg)
    `ASSERT_NEXT_CYCLE(a_inc_holds_unless_accept, clk, rst_n, !accept, $stable(s1_inc_reg))
    `ASSERT_SAME_CYCLE(a_inc_nonzero, clk, rst_n, result.valid, result.increment_now != '0)

endmodule

// ===== dv/dds_warble_tone_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_warble_tone_generator_tb
// Self-checking testbench for the warble tone generator. Tick words are sent
// in random bursts, and sample words are taken back under a stall pattern of
// the receiver's own. A predictor in the testbench tracks phase, increment,
// tick counter and warble direction, and queues the sample word that each
// accepted tick must give. The run starts with short directed tests of the
// register extremes and the corner cases of the warble logic. Random register
// settings and tick streams follow, and then a long output stall that fills
// the pipeline.
// ----------------------------------------------------------------------------
module dds_warble_tone_generator_tb;
    import dwt_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int ROM_DEPTH   = 1024;
    localparam int MIDSCALE    = 1 << (SAMPLE_BITS - 1);
    localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
    localparam int IDLE_LIMIT  = 2000;
    localparam int REPORT_MAX  = 40;
    localparam real TWO_PI     = 6.283185307179586;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [INC_W-1:0]       increment_now;
    } sample_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    dwt_tick_if                                tick_ch ();
    dwt_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

    dds_warble_tone_generator #(
        .TABLE_DEPTH (ROM_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .result    (result_ch)
    );

    // Tone state as the predictor sees it.
    int                  sine_rom [ROM_DEPTH];
    logic [INC_W-1:0]    tone_phase;
    logic [INC_W-1:0]    tone_increment;
    logic [TICKS_W-1:0]  toggle_count;
    logic                rise_pending;
    logic [VOLUME_W-1:0] reg_volume;
    logic [INC_W-1:0]    reg_inc_upper;
    logic [STEP_W-1:0]   reg_sweep_step;
    logic [TICKS_W-1:0]  reg_ticks;

    sample_word_t expected_samples [$];
    int           mismatch_count = 0;
    int           burst_left     = 0;
    bit           sender_bursty  = 1'b1;
    int           hold_request   = 0;

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void build_sine_rom();
        for (int i = 0; i < ROM_DEPTH; i++)
            sine_rom[i] = $rtoi($sin(TWO_PI * i / ROM_DEPTH) * 2047.0);
    endfunction

    function automatic void reset_tone_state();
        tone_phase     = '0;
        tone_increment = INC_RESET;
        toggle_count   = '0;
        rise_pending   = 1'b0;
        reg_volume     = VOLUME_RESET;
        reg_inc_upper  = INC_UPPER_RESET;
        reg_sweep_step = STEP_RESET;
        reg_ticks      = TICKS_RESET;
    endfunction

    // Works out the sample word of one tick and advances the tone state.
    function automatic void predict_tick(input logic enable);
        sample_word_t word;
        int           level;
        int           next_inc;
        int           ceiling;
        level = (sine_rom[tone_phase] / VOLUME_DIVISOR) * int'(reg_volume) + MIDSCALE;
        if (level < 0)
            level = 0;
        if (level > FULL_SCALE)
            level = FULL_SCALE;
        tone_phase = tone_phase + tone_increment;
        if (int'(toggle_count) + 1 >= int'(reg_ticks))
        begin
            toggle_count = '0;
            if (enable)
            begin
                next_inc = int'(tone_increment);
                if (rise_pending)
                begin
                    // A zero ceiling behaves as a ceiling of one.
                    ceiling  = (reg_inc_upper == '0) ? 1 : int'(reg_inc_upper);
                    next_inc = next_inc + int'(reg_sweep_step);
                    if (next_inc > ceiling)
                        next_inc = ceiling;
                end
                else
                begin
                    next_inc = next_inc - int'(reg_sweep_step);
                    if (next_inc < 1)
                        next_inc = 1;
                end
                rise_pending   = !rise_pending;
                tone_increment = INC_W'(next_inc);
            end
        end
        else
        begin
            toggle_count = toggle_count + 1'b1;
        end
        word.sample        = SAMPLE_BITS'(level);
        word.increment_now = tone_increment;
        expected_samples.push_back(word);
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken, or after a random gap once a burst ends.
    task automatic send_tick(input logic enable);
        int gap;
        tick_ch.valid         <= 1'b1;
        tick_ch.warble_enable <= enable;
        @(negedge clk);
        while (!tick_ch.ready)
            @(negedge clk);
        predict_tick(enable);
        @(posedge clk);
        if (sender_bursty)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                tick_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic send_ticks(input int count, input int warble_pct);
        for (int k = 0; k < count; k++)
            send_tick($urandom_range(1, 100) <= warble_pct);
        tick_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    // Upper bits beyond the register width carry junk that must be dropped.
    task automatic write_reg(input cfg_reg_t which, input int value);
        logic [CFG_DATA_W-1:0] data;
        wait_drained();
        data = CFG_DATA_W'($urandom);
        case (which)
            CFG_VOLUME:           data[VOLUME_W-1:0] = VOLUME_W'(value);
            CFG_INCREMENT_UPPER:  data[INC_W-1:0]    = INC_W'(value);
            CFG_SWEEP_STEP:       data[STEP_W-1:0]   = STEP_W'(value);
            CFG_TICKS_PER_TOGGLE: data[TICKS_W-1:0]  = TICKS_W'(value);
            default:              data               = data;
        endcase
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= which;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (which)
            CFG_VOLUME:           reg_volume     = data[VOLUME_W-1:0];
            CFG_INCREMENT_UPPER:  reg_inc_upper  = data[INC_W-1:0];
            CFG_SWEEP_STEP:       reg_sweep_step = data[STEP_W-1:0];
            CFG_TICKS_PER_TOGGLE: reg_ticks      = data[TICKS_W-1:0];
            default:              reg_ticks      = reg_ticks;
        endcase
    endtask

    task automatic randomize_registers();
        int value;
        case ($urandom_range(0, 5))
            0:       value = 0;
            1:       value = 100;
            2:       value = 127;
            default: value = $urandom_range(0, 127);
        endcase
        write_reg(CFG_VOLUME, value);
        case ($urandom_range(0, 6))
            0:       value = 0;
            1:       value = 1;
            2:       value = 1023;
            default: value = $urandom_range(1, 1023);
        endcase
        write_reg(CFG_INCREMENT_UPPER, value);
        case ($urandom_range(0, 5))
            0:       value = 0;
            1:       value = 63;
            default: value = $urandom_range(0, 63);
        endcase
        write_reg(CFG_SWEEP_STEP, value);
        case ($urandom_range(0, 7))
            0:       value = 0;
            1:       value = 65535;
            2:       value = $urandom_range(100, 65534);
            default: value = $urandom_range(1, 24);
        endcase
        write_reg(CFG_TICKS_PER_TOGGLE, value);
    endtask

    task automatic test_reset_values();
        send_ticks(2, 0);
        send_ticks(2, 100);
    endtask

    // Volumes above 102 overdrive the sine peak into saturation.
    task automatic test_volume_extremes();
        write_reg(CFG_VOLUME, 127);
        send_ticks(3, 50);
        write_reg(CFG_VOLUME, 0);
        send_ticks(1, 50);
        write_reg(CFG_VOLUME, 100);
        send_ticks(1, 50);
    endtask

    // A zero period wraps on every tick; a zero ceiling limits rises to one.
    task automatic test_zero_period_and_ceiling();
        write_reg(CFG_TICKS_PER_TOGGLE, 0);
        write_reg(CFG_SWEEP_STEP, 63);
        write_reg(CFG_INCREMENT_UPPER, 0);
        send_ticks(3, 100);
        write_reg(CFG_INCREMENT_UPPER, 1023);
        send_ticks(2, 100);
    endtask

    task automatic test_zero_step();
        write_reg(CFG_SWEEP_STEP, 0);
        write_reg(CFG_TICKS_PER_TOGGLE, 1);
        send_ticks(2, 100);
        send_ticks(1, 0);
    endtask

    // A drop only floors at one, so an increment above a lowered ceiling
    // can stay above it until the next rise.
    task automatic test_increment_above_ceiling();
        write_reg(CFG_SWEEP_STEP, 63);
        send_ticks(4, 100);
        write_reg(CFG_INCREMENT_UPPER, 2);
        send_ticks(3, 100);
    endtask

    // A period lowered below the running count wraps on the next tick.
    task automatic test_period_lowered();
        write_reg(CFG_TICKS_PER_TOGGLE, 65535);
        send_ticks(3, 100);
        write_reg(CFG_TICKS_PER_TOGGLE, 2);
        send_ticks(2, 100);
    endtask

    task automatic test_random_warble();
        for (int p = 0; p < 30; p++)
        begin
            randomize_registers();
            sender_bursty = ($urandom_range(0, 3) != 0);
            send_ticks($urandom_range(40, 76), 85);
        end
        sender_bursty = 1'b1;
    endtask

    // The receiver holds off long enough for the pipeline to fill while the
    // sender keeps a tick word on offer.
    task automatic test_output_backpressure();
        write_reg(CFG_TICKS_PER_TOGGLE, 3);
        write_reg(CFG_VOLUME, 77);
        sender_bursty = 1'b0;
        hold_request  = 300;
        send_ticks(90, 70);
        sender_bursty = 1'b1;
    endtask

    initial
    begin : result_ready_gen
        int hold_left;
        int mode_left;
        int stall_pct;
        hold_left       = 0;
        mode_left       = 0;
        stall_pct       = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(32, 256);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(1, 100) > stall_pct);
            end
        end
    end

    // Handshakes are sampled at the falling edge; inputs only move at the
    // rising edge, so a word seen here is taken at the next rising edge.
    initial
    begin : sample_checker
        sample_word_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    report_mismatch($sformatf("sample word %0d with no tick pending",
                                              result_ch.sample));
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (result_ch.sample !== want.sample)
                        report_mismatch($sformatf("sample %0d, predicted %0d",
                                                  result_ch.sample, want.sample));
                    if (result_ch.increment_now !== want.increment_now)
                        report_mismatch($sformatf("increment_now %0d, predicted %0d",
                                                  result_ch.increment_now,
                                                  want.increment_now));
                end
            end
        end
    end

    initial
    begin : stall_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(negedge clk);
            if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)
                || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_write             = 1'b0;
        cfg_index             = CFG_VOLUME;
        cfg_data              = '0;
        tick_ch.valid         = 1'b0;
        tick_ch.warble_enable = 1'b0;
        build_sine_rom();
        reset_tone_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_volume_extremes();
        test_zero_period_and_ceiling();
        test_zero_step();
        test_increment_above_ceiling();
        test_period_lowered();
        test_random_warble();
        test_output_backpressure();

        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_samples.size() != 0)
            report_mismatch($sformatf("%0d sample words never arrived",
                                      expected_samples.size()));
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dwt_pkg.sv
hw/rtl/dwt_if.sv
hw/rtl/dwt_ctrl.sv
hw/rtl/dwt_sine_rom.sv
hw/rtl/dwt_scale.sv
hw/rtl/dds_warble_tone_generator.sv
dv/dds_warble_tone_generator_tb.sv
